// ----- src/nfci_pkg.sv -----
// shared types and constants of the nor flash command interface
package nfci_pkg;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] word_address;
		logic [15:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        busy_res;
	} out_item_t;

	typedef enum logic [2:0] {
		CFG_ID_ONE        = 3'd0,
		CFG_ID_TWO        = 3'd1,
		CFG_ID_THREE      = 3'd2,
		CFG_PROGRAM_TICKS = 3'd3,
		CFG_BUFFER_TICKS  = 3'd4,
		CFG_ERASE_TICKS   = 3'd5
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'd0,
		ST_UNL1 = 4'd1,
		ST_UNL2 = 4'd2,
		ST_PROG = 4'd3,
		ST_ERS0 = 4'd4,
		ST_ERS1 = 4'd5,
		ST_ERS2 = 4'd6,
		ST_BCNT = 4'd7,
		ST_BDAT = 4'd8,
		ST_BCNF = 4'd9
	} stage_t;

	typedef enum logic [2:0] {
		OP_DIRECT  = 3'd0,
		OP_ARRAY   = 3'd1,
		OP_PROGRAM = 3'd2,
		OP_ERASE   = 3'd3,
		OP_COMMIT  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		B_INIT   = 3'd0,
		B_IDLE   = 3'd1,
		B_RD     = 3'd2,
		B_RMW_RD = 3'd3,
		B_RMW_WR = 3'd4,
		B_DIV    = 3'd5,
		B_ERS    = 3'd6
	} back_state_t;

	localparam int CNT_W = 9;

	typedef struct packed {
		op_t              op;
		logic [11:0]      addr;
		logic [15:0]      data;
		logic [CNT_W-1:0] count;
		logic             busy;
	} queue_entry_t;

	typedef struct packed {
		logic init;
		logic idle;
	} back_status_t;

	localparam logic [15:0] CMD_UNLOCK1  = 16'h00AA;
	localparam logic [15:0] CMD_UNLOCK2  = 16'h0055;
	localparam logic [10:0] ADDR_UNLOCK1 = 11'h555;
	localparam logic [10:0] ADDR_UNLOCK2 = 11'h2AA;
	localparam logic [15:0] CMD_ERASE    = 16'h0080;
	localparam logic [15:0] CMD_SECTOR   = 16'h0030;
	localparam logic [15:0] CMD_BUFFER   = 16'h0025;
	localparam logic [15:0] CMD_CONFIRM  = 16'h0029;
	localparam logic [15:0] CMD_AUTOSEL  = 16'h0090;
	localparam logic [15:0] CMD_RESET    = 16'h00F0;
	localparam logic [15:0] CMD_PROGRAM  = 16'h00A0;
	localparam logic [15:0] MANUF_ID     = 16'h0001;
	localparam logic [7:0]  ID_OFS_MANUF = 8'h00;
	localparam logic [7:0]  ID_OFS_ONE   = 8'h01;
	localparam logic [7:0]  ID_OFS_TWO   = 8'h0E;
	localparam logic [7:0]  ID_OFS_THREE = 8'h0F;

endpackage

// ----- src/nfci_ram.sv -----
// generic single write port ram with registered read
module nfci_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/nfci_queue.sv -----
// two entry queue between the command front and the array engine
module nfci_queue
	import nfci_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  queue_entry_t push_entry,
	input  logic         pop,
	output queue_entry_t head,
	output logic         not_empty,
	output logic         not_full
);
	queue_entry_t entry_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   fill_q;

	assign head      = entry_q[rd_q];
	assign not_empty = fill_q != 2'd0;
	assign not_full  = fill_q != 2'd2;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- src/nfci_front.sv -----
// command decoder: config registers, command sequence, busy timer, buffer loading
module nfci_front
	import nfci_pkg::*;
#(
	parameter int BUFFER_WORDS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  in_item_t     in_data,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  back_status_t back_status,
	input  logic         queue_not_full,
	input  logic         queue_not_empty,
	output logic         push,
	output queue_entry_t push_entry,
	output logic         buf_we,
	output logic [(BUFFER_WORDS > 1 ? $clog2(BUFFER_WORDS) : 1)-1:0] buf_waddr,
	output logic [15:0]  buf_wdata
);
	localparam int BAW = BUFFER_WORDS > 1 ? $clog2(BUFFER_WORDS) : 1;

	logic [15:0]      id_one_q, id_two_q, id_three_q;
	logic [15:0]      prog_ticks_q, buf_ticks_q, erase_ticks_q;
	stage_t           stage_q, stage_d;
	logic             auto_q, auto_d;
	logic [15:0]      busy_q, busy_d;
	logic             toggle_q, toggle_d;
	logic [11:0]      base_q, base_d;
	logic [CNT_W-1:0] remain_q, remain_d;
	logic [CNT_W-1:0] loaded_q, loaded_d;
	logic             accept;
	logic [10:0]      cmd_addr;
	logic [15:0]      wdat;
	logic [11:0]      addr;
	logic [15:0]      id_word;
	logic             at_unl1, at_unl2;

	assign cfg_ready = 1'b1;
	// buffer words wait until any earlier commit has drained
	assign in_ready = !back_status.init && queue_not_full &&
		!(stage_q == ST_BDAT && (queue_not_empty || !back_status.idle));
	assign accept   = in_valid && in_ready;
	assign addr     = in_data.word_address;
	assign wdat     = in_data.write_data;
	assign cmd_addr = addr[10:0];
	assign at_unl1  = wdat == CMD_UNLOCK1 && cmd_addr == ADDR_UNLOCK1;
	assign at_unl2  = wdat == CMD_UNLOCK2 && cmd_addr == ADDR_UNLOCK2;

	always_comb begin
		case (addr[7:0])
			ID_OFS_MANUF: id_word = MANUF_ID;
			ID_OFS_ONE:   id_word = id_one_q;
			ID_OFS_TWO:   id_word = id_two_q;
			ID_OFS_THREE: id_word = id_three_q;
			default:      id_word = 16'h0000;
		endcase
	end

	always_comb begin
		stage_d    = stage_q;
		auto_d     = auto_q;
		busy_d     = busy_q;
		toggle_d   = toggle_q;
		base_d     = base_q;
		remain_d   = remain_q;
		loaded_d   = loaded_q;
		push       = 1'b0;
		push_entry = '{op: OP_DIRECT, addr: addr, data: wdat, count: '0, busy: 1'b0};
		buf_we     = 1'b0;
		buf_waddr  = loaded_q[BAW-1:0];
		buf_wdata  = wdat;
		if (accept) begin
			unique case (in_data.action)
				ACT_READ: begin
					push = 1'b1;
					if (busy_q != 16'd0) begin
						push_entry.data = {9'd0, toggle_q, 6'd0};
						push_entry.busy = 1'b1;
						toggle_d        = ~toggle_q;
					end else if (auto_q) begin
						push_entry.data = id_word;
					end else begin
						push_entry.op = OP_ARRAY;
					end
				end
				ACT_WRITE: begin
					if (busy_q == 16'd0) begin
						stage_d = ST_IDLE;
						if (auto_q) begin
							if (wdat == CMD_RESET) begin
								auto_d = 1'b0;
							end
						end else begin
							unique case (stage_q)
								ST_IDLE: if (at_unl1) stage_d = ST_UNL1;
								ST_UNL1: if (at_unl2) stage_d = ST_UNL2;
								ST_UNL2: begin
									if (wdat == CMD_PROGRAM && cmd_addr == ADDR_UNLOCK1) begin
										stage_d = ST_PROG;
									end else if (wdat == CMD_ERASE && cmd_addr == ADDR_UNLOCK1) begin
										stage_d = ST_ERS0;
									end else if (wdat == CMD_AUTOSEL && cmd_addr == ADDR_UNLOCK1) begin
										auto_d = 1'b1;
									end else if (wdat == CMD_BUFFER) begin
										stage_d = ST_BCNT;
									end
								end
								ST_PROG: begin
									push            = 1'b1;
									push_entry.op   = OP_PROGRAM;
									push_entry.count = CNT_W'(1);
									busy_d          = prog_ticks_q;
								end
								ST_ERS0: if (at_unl1) stage_d = ST_ERS1;
								ST_ERS1: if (at_unl2) stage_d = ST_ERS2;
								ST_ERS2: begin
									if (wdat == CMD_SECTOR) begin
										push          = 1'b1;
										push_entry.op = OP_ERASE;
										busy_d        = erase_ticks_q;
									end
								end
								ST_BCNT: begin
									if (wdat <= 16'(BUFFER_WORDS - 1)) begin
										remain_d = wdat[CNT_W-1:0] + CNT_W'(1);
										loaded_d = '0;
										stage_d  = ST_BDAT;
									end
								end
								ST_BDAT: begin
									if (loaded_q == '0 || addr == base_q + 12'(loaded_q)) begin
										if (loaded_q == '0) begin
											base_d = addr;
										end
										buf_we   = 1'b1;
										loaded_d = loaded_q + CNT_W'(1);
										remain_d = remain_q - CNT_W'(1);
										stage_d  = (remain_q == CNT_W'(1)) ? ST_BCNF : ST_BDAT;
									end
								end
								ST_BCNF: begin
									if (wdat == CMD_CONFIRM) begin
										push             = 1'b1;
										push_entry.op    = OP_COMMIT;
										push_entry.addr  = base_q;
										push_entry.count = loaded_q;
										busy_d           = buf_ticks_q;
									end
								end
								default: stage_d = ST_IDLE;
							endcase
						end
					end
				end
				ACT_TICK: begin
					if (busy_q != 16'd0) begin
						busy_d = busy_q - 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q       <= ST_IDLE;
			auto_q        <= 1'b0;
			busy_q        <= 16'd0;
			toggle_q      <= 1'b0;
			base_q        <= 12'd0;
			remain_q      <= '0;
			loaded_q      <= '0;
			id_one_q      <= 16'd8830;
			id_two_q      <= 16'd33;
			id_three_q    <= 16'd1;
			prog_ticks_q  <= 16'd8;
			buf_ticks_q   <= 16'd16;
			erase_ticks_q <= 16'd1024;
		end else begin
			stage_q  <= stage_d;
			auto_q   <= auto_d;
			busy_q   <= busy_d;
			toggle_q <= toggle_d;
			base_q   <= base_d;
			remain_q <= remain_d;
			loaded_q <= loaded_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ID_ONE:        id_one_q      <= cfg_data;
					CFG_ID_TWO:        id_two_q      <= cfg_data;
					CFG_ID_THREE:      id_three_q    <= cfg_data;
					CFG_PROGRAM_TICKS: prog_ticks_q  <= cfg_data;
					CFG_BUFFER_TICKS:  buf_ticks_q   <= cfg_data;
					CFG_ERASE_TICKS:   erase_ticks_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- src/nfci_back.sv -----
// array engine: clear pass, reads, read-modify-write programs, sector erase sweep
module nfci_back
	import nfci_pkg::*;
#(
	parameter int ARRAY_WORDS  = 4096,
	parameter int SECTOR_WORDS = 512,
	parameter int BUFFER_WORDS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  queue_entry_t head,
	input  logic         queue_not_empty,
	output logic         pop,
	output back_status_t back_status,
	output logic [(BUFFER_WORDS > 1 ? $clog2(BUFFER_WORDS) : 1)-1:0] buf_raddr,
	input  logic [15:0]  buf_rdata,
	output logic         out_valid,
	input  logic         out_ready,
	output out_item_t    out_data
);
	localparam int AW  = $clog2(ARRAY_WORDS);
	localparam int BAW = BUFFER_WORDS > 1 ? $clog2(BUFFER_WORDS) : 1;
	localparam int XW  = (AW > 12 ? AW : 12) + 1;
	localparam int SCW = $clog2(SECTOR_WORDS);
	localparam int SH  = AW + SCW;
	localparam int MW  = AW + 2;
	localparam int PW  = AW + MW;
	localparam int BW  = AW + SCW + 1;
	// rounded-up reciprocal of the sector size, exact for every array index
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(SECTOR_WORDS) - 64'd1) / 64'(SECTOR_WORDS);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

	back_state_t      state_q, state_d;
	logic [AW-1:0]    cur_q, cur_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [15:0]      mask_q, mask_d;
	logic             use_buf_q, use_buf_d;
	logic [AW-1:0]    quo_q, quo_d;
	logic             phase_q, phase_d;
	logic [SCW-1:0]   sn_q, sn_d;
	out_item_t        out_q, out_d;
	logic             out_valid_q, out_valid_d;
	logic             out_free;
	logic [XW-1:0]    head_ext;
	logic [AW-1:0]    head_idx;
	logic [AW-1:0]    cur_inc;
	logic [PW-1:0]    recip_prod;
	logic [BW-1:0]    base_prod;
	logic             we;
	logic [AW-1:0]    raddr;
	logic [15:0]      wdata, rdata;

	// word address folded into the array by one subtract, enough while ARRAY_WORDS is at least 2048
	assign head_ext = XW'(head.addr);
	assign head_idx = (head_ext >= XW'(ARRAY_WORDS)) ?
		AW'(head_ext - XW'(ARRAY_WORDS)) : AW'(head_ext);
	assign cur_inc  = (cur_q == AW'(ARRAY_WORDS - 1)) ? '0 : cur_q + AW'(1);
	assign out_free = !out_valid_q || out_ready;
	assign buf_raddr = k_q[BAW-1:0];
	assign back_status = '{init: state_q == B_INIT, idle: state_q == B_IDLE};
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign recip_prod = PW'(cur_q) * PW'(RECIP_M);
	assign base_prod  = BW'(quo_q) * BW'(SECTOR_WORDS);

	nfci_ram #(.WIDTH(16), .DEPTH(ARRAY_WORDS)) u_array (
		.clk  (clk),
		.we   (we),
		.waddr(cur_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		k_d         = k_q;
		cnt_d       = cnt_q;
		mask_d      = mask_q;
		use_buf_d   = use_buf_q;
		quo_d       = quo_q;
		phase_d     = phase_q;
		sn_d        = sn_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !out_ready;
		pop         = 1'b0;
		we          = 1'b0;
		wdata       = 16'hFFFF;
		raddr       = cur_q;
		unique case (state_q)
			B_INIT: begin
				we = 1'b1;
				if (cur_q == AW'(ARRAY_WORDS - 1)) begin
					state_d = B_IDLE;
				end else begin
					cur_d = cur_q + AW'(1);
				end
			end
			B_IDLE: begin
				raddr = head_idx;
				if (queue_not_empty) begin
					unique case (head.op)
						OP_DIRECT: begin
							if (out_free) begin
								pop         = 1'b1;
								out_d       = '{read_data: head.data, busy_res: head.busy};
								out_valid_d = 1'b1;
							end
						end
						OP_ARRAY: begin
							if (out_free) begin
								pop     = 1'b1;
								state_d = B_RD;
							end
						end
						OP_PROGRAM, OP_COMMIT: begin
							pop       = 1'b1;
							cur_d     = head_idx;
							k_d       = '0;
							cnt_d     = head.count;
							mask_d    = head.data;
							use_buf_d = head.op == OP_COMMIT;
							if (head.count != '0) begin
								state_d = B_RMW_RD;
							end
						end
						OP_ERASE: begin
							pop     = 1'b1;
							cur_d   = head_idx;
							phase_d = 1'b0;
							state_d = B_DIV;
						end
						default: ;
					endcase
				end
			end
			B_RD: begin
				out_d       = '{read_data: rdata, busy_res: 1'b0};
				out_valid_d = 1'b1;
				state_d     = B_IDLE;
			end
			B_RMW_RD: begin
				state_d = B_RMW_WR;
			end
			B_RMW_WR: begin
				we    = 1'b1;
				wdata = rdata & (use_buf_q ? buf_rdata : mask_q);
				k_d   = k_q + CNT_W'(1);
				cur_d = cur_inc;
				state_d = (k_q + CNT_W'(1) == cnt_q) ? B_IDLE : B_RMW_RD;
			end
			B_DIV: begin
				// sector number by reciprocal multiplication, then its base word
				if (!phase_q) begin
					quo_d   = AW'(recip_prod >> SH);
					phase_d = 1'b1;
				end else begin
					cur_d   = AW'(base_prod);
					sn_d    = '0;
					state_d = B_ERS;
				end
			end
			B_ERS: begin
				we = 1'b1;
				if (sn_q == SCW'(SECTOR_WORDS - 1) || cur_q == AW'(ARRAY_WORDS - 1)) begin
					state_d = B_IDLE;
				end else begin
					cur_d = cur_q + AW'(1);
					sn_d  = sn_q + SCW'(1);
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		k_q       <= k_d;
		cnt_q     <= cnt_d;
		mask_q    <= mask_d;
		use_buf_q <= use_buf_d;
		quo_q     <= quo_d;
		phase_q   <= phase_d;
		sn_q      <= sn_d;
		out_q     <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_INIT;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_q       <= cur_d;
			out_valid_q <= out_valid_d;
		end
	end
endmodule

// ----- src/nor_flash_command_interface_top.sv -----
// top level of the x16 nor flash command interface model
//
// in channel: one beat per bus read, bus write or time tick (in_data.action).
// every bus read gives exactly one out beat: array word, id word in autoselect
// mode, or a status word with a toggling bit 6 and busy_res set while busy.
// writes and ticks give no out beat. cfg channel writes the six registers,
// always ready, to be used while the block is idle.
// a front decoder runs the command sequence and the busy timer in the cycle
// of acceptance and queues array work into a two entry queue; the array
// engine behind it owns the single write port array memory.
// every read waits behind any array work still queued ahead of it.
// throughput: one in beat a cycle while the queue has room; the engine
// serves status and id reads one a cycle while out_ready is high and takes
// no new item during an array read until it returns from B_RD. a word
// program reads then writes its word (B_RMW_RD, B_RMW_WR), a buffered write
// does so for each word, and a sector erase finds the sector base (B_DIV),
// then writes each sector word (B_ERS). after reset the engine clears the
// array to all ones with in_ready low. buffer data beats wait for a
// previous commit to drain. when out_ready is low the result holds in the
// output register and the queue backs up until in_ready drops.
module nor_flash_command_interface_top
	import nfci_pkg::*;
#(
	parameter int ARRAY_WORDS  = 4096,
	parameter int SECTOR_WORDS = 512,
	parameter int BUFFER_WORDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int BAW = BUFFER_WORDS > 1 ? $clog2(BUFFER_WORDS) : 1;

	back_status_t   back_status;
	logic           push, pop, q_not_empty, q_not_full;
	queue_entry_t   push_entry, head;
	logic           buf_we;
	logic [BAW-1:0] buf_waddr, buf_raddr;
	logic [15:0]    buf_wdata, buf_rdata;

	nfci_front #(.BUFFER_WORDS(BUFFER_WORDS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.back_status    (back_status),
		.queue_not_full (q_not_full),
		.queue_not_empty(q_not_empty),
		.push           (push),
		.push_entry     (push_entry),
		.buf_we         (buf_we),
		.buf_waddr      (buf_waddr),
		.buf_wdata      (buf_wdata)
	);

	nfci_ram #(.WIDTH(16), .DEPTH(BUFFER_WORDS)) u_buffer (
		.clk  (clk),
		.we   (buf_we),
		.waddr(buf_waddr),
		.wdata(buf_wdata),
		.raddr(buf_raddr),
		.rdata(buf_rdata)
	);

	nfci_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.not_empty (q_not_empty),
		.not_full  (q_not_full)
	);

	nfci_back #(
		.ARRAY_WORDS (ARRAY_WORDS),
		.SECTOR_WORDS(SECTOR_WORDS),
		.BUFFER_WORDS(BUFFER_WORDS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.queue_not_empty(q_not_empty),
		.pop            (pop),
		.back_status    (back_status),
		.buf_raddr      (buf_raddr),
		.buf_rdata      (buf_rdata),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data)
	);
endmodule
